// ===== hdl/deque_pkg.sv =====
`timescale 1ns / 1ps
package deque_pkg;

  // Fixed field widths
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  // Default number of stored words
  localparam int DQ_DEPTH = 16;

  // Operation codes carried in kind
  typedef enum logic [KIND_W-1:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_REAR  = 3'd1,
    K_POP_FRONT  = 3'd2,
    K_POP_REAR   = 3'd3,
    K_DUMP       = 3'd4
  } kind_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    push_front;
    logic    push_rear;
    logic    pop_front;
    logic    pop_rear;
    logic    dump;
    logic    load_imm;
    status_t imm_status;
    logic    load_rd;
  } dq_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic rem_last;
    logic out_free;
  } dq_stat_t;

endpackage

// ===== hdl/deque_ram.sv =====
`timescale 1ns / 1ps
module deque_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/deque_ctrl.sv =====
`timescale 1ns / 1ps
module deque_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [deque_pkg::KIND_W-1:0] kind,
  input  deque_pkg::dq_stat_t          stat,
  output deque_pkg::dq_cmd_t           cmd
);

  import deque_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;

  // New item only when idle and the output register can take a result
  assign in_stall = !((state == S_IDLE) && stat.out_free);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind)
            K_POP_FRONT, K_POP_REAR, K_DUMP: begin
              if (!stat.empty) begin
                state_next = S_READ;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        if (stat.out_free && stat.rem_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd            = '0;
    cmd.imm_status = ST_OK;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (kind)
            K_PUSH_FRONT, K_PUSH_REAR: begin
              cmd.load_imm = 1'b1;
              if (stat.full) begin
                cmd.imm_status = ST_FULL;
              end else begin
                cmd.push_front = (kind == K_PUSH_FRONT);
                cmd.push_rear  = (kind == K_PUSH_REAR);
              end
            end
            K_POP_FRONT, K_POP_REAR: begin
              if (stat.empty) begin
                cmd.load_imm   = 1'b1;
                cmd.imm_status = ST_EMPTY;
              end else begin
                cmd.pop_front = (kind == K_POP_FRONT);
                cmd.pop_rear  = (kind == K_POP_REAR);
              end
            end
            K_DUMP: begin
              if (stat.empty) begin
                cmd.load_imm   = 1'b1;
                cmd.imm_status = ST_EMPTY;
              end else begin
                cmd.dump = 1'b1;
              end
            end
            default: ;  // unused codes: dropped, no result
          endcase
        end
      end
      S_READ: begin
        cmd.load_rd = stat.out_free;
      end
      default: cmd.load_rd = 1'b0;
    endcase
  end

endmodule

// ===== hdl/deque_dpath.sv =====
`timescale 1ns / 1ps
module deque_dpath #(
  parameter int DEPTH = deque_pkg::DQ_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [deque_pkg::DATA_W-1:0]   value,
  input  deque_pkg::dq_cmd_t                    cmd,
  output deque_pkg::dq_stat_t                   stat,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic        [deque_pkg::STATUS_W-1:0] status,
  output logic signed [deque_pkg::DATA_W-1:0]   data,
  output logic                                  last
);

  import deque_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  head_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [IDX_W-1:0]  rptr;
  logic [IDX_W-1:0]  rptr_next;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  rem_next;

  logic [IDX_W-1:0]  head_dec;
  logic [IDX_W-1:0]  head_inc;
  logic [IDX_W-1:0]  rptr_inc;
  logic [SUM_W-1:0]  tail_sum;
  logic [SUM_W-1:0]  rear_sum;
  logic [IDX_W-1:0]  tail_idx;
  logic [IDX_W-1:0]  rear_idx;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] rdata;

  // Ring index arithmetic
  assign head_dec = (head == '0) ? IDX_W'(DEPTH - 1) : head - IDX_W'(1);
  assign head_inc = (head == IDX_W'(DEPTH - 1)) ? '0 : head + IDX_W'(1);
  assign rptr_inc = (rptr == IDX_W'(DEPTH - 1)) ? '0 : rptr + IDX_W'(1);

  // Slot after the rear word, and the rear word itself
  assign tail_sum = SUM_W'(head) + SUM_W'(count);
  assign rear_sum = tail_sum - SUM_W'(1);
  assign tail_idx = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                : IDX_W'(tail_sum);
  assign rear_idx = (rear_sum >= SUM_W'(DEPTH)) ? IDX_W'(rear_sum - SUM_W'(DEPTH))
                                                : IDX_W'(rear_sum);

  // Status to controller
  assign stat.full     = (count == CNT_W'(DEPTH));
  assign stat.empty    = (count == '0);
  assign stat.rem_last = (rem == CNT_W'(1));
  assign stat.out_free = !out_valid || !out_stall;

  // Pointer and counter updates
  always_comb begin
    head_next  = head;
    count_next = count;
    rptr_next  = rptr;
    rem_next   = rem;
    we         = 1'b0;
    waddr      = tail_idx;
    if (cmd.push_front) begin
      we         = 1'b1;
      waddr      = head_dec;
      head_next  = head_dec;
      count_next = count + CNT_W'(1);
    end
    if (cmd.push_rear) begin
      we         = 1'b1;
      waddr      = tail_idx;
      count_next = count + CNT_W'(1);
    end
    if (cmd.pop_front) begin
      rptr_next  = head;
      rem_next   = CNT_W'(1);
      head_next  = head_inc;
      count_next = count - CNT_W'(1);
    end
    if (cmd.pop_rear) begin
      rptr_next  = rear_idx;
      rem_next   = CNT_W'(1);
      count_next = count - CNT_W'(1);
    end
    if (cmd.dump) begin
      rptr_next = head;
      rem_next  = count;
    end
    if (cmd.load_rd) begin
      rptr_next = rptr_inc;
      rem_next  = rem - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      rem   <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
      rem   <= rem_next;
    end
    rptr <= rptr_next;
  end

  // Word store; read address follows rptr_next so rdata matches rptr
  deque_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (value),
    .raddr (rptr_next),
    .rdata (rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_imm || cmd.load_rd) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_imm) begin
      status <= cmd.imm_status;
      data   <= '0;
      last   <= 1'b1;
    end else if (cmd.load_rd) begin
      status <= ST_OK;
      data   <= rdata;
      last   <= stat.rem_last;
    end
  end

endmodule

// ===== hdl/double_ended_queue.sv =====
`timescale 1ns / 1ps
// Channel  Handshake            Fields
// in       in_valid / in_stall  kind[2:0], value[31:0] signed
// out      out_valid / out_stall status[1:0], data[31:0] signed, last
//
// Push, and any item answered at once (full or empty): result registered as the
// item is accepted. Pop: the registered read of the word store, then the output
// register. Dump: the first read as for a pop, then one word per cycle.
// An item is taken when the controller is idle and the output register is free
// or being emptied; out_stall holds the current result and pauses a dump.
// Reset clears head, count and the controller; the word store is not cleared.
module double_ended_queue #(
  parameter int DEPTH = deque_pkg::DQ_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic        [deque_pkg::KIND_W-1:0]   kind,
  input  logic signed [deque_pkg::DATA_W-1:0]   value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic        [deque_pkg::STATUS_W-1:0] status,
  output logic signed [deque_pkg::DATA_W-1:0]   data,
  output logic                                  last
);

  import deque_pkg::*;

  dq_cmd_t  cmd;
  dq_stat_t stat;

  deque_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .stat     (stat),
    .cmd      (cmd)
  );

  deque_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .data      (data),
    .last      (last)
  );

endmodule
